// ===== rtl/core/assert_macros.svh =====
// Assertion helper macros for the RTL files; the mapper core uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_AR(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_AR(label, clk, rst_n, prop)
`define ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== rtl/core/scsm_pkg.sv =====
// ----------------------------------------------------------------------------
// scsm_pkg
// Shared types and constants of the stick circle-to-square mapper.
// ----------------------------------------------------------------------------
package scsm_pkg;

  localparam int unsigned CENTER    = 127;
  localparam int unsigned MAX_POW   = 15;
  localparam int unsigned CFG_WIDTH = 4;

  // Control and sample data that travels alongside every pipeline cell.
  typedef struct packed {
    logic              valid;
    logic signed [8:0] a;
    logic signed [8:0] b;
    logic [7:0]        m;
  } side_t;

endpackage

// ===== rtl/core/scsm_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// scsm_sqrt_cell
// One bit of a pipelined integer square root, one cell per result bit.
// ----------------------------------------------------------------------------
module scsm_sqrt_cell
  import scsm_pkg::*;
#(
  parameter int unsigned W  = 48,
  parameter int unsigned SH = 0
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  side_t        side_i,
  input  logic [W-1:0] v_i,
  input  logic [W-1:0] res_i,
  output side_t        side_o,
  output logic [W-1:0] v_o,
  output logic [W-1:0] res_o
);

  logic [W-1:0] bit_w;
  logic [W-1:0] sum;
  logic [W-1:0] v_d, res_d;
  side_t        side_q;
  logic [W-1:0] v_q, res_q;

  assign bit_w = W'(1) << SH;
  assign sum   = res_i + bit_w;

  always_comb begin
    if (v_i >= sum) begin
      v_d   = v_i - sum;
      res_d = (res_i >> 1) + bit_w;
    end else begin
      v_d   = v_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q   <= v_d;
      res_q <= res_d;
    end
  end

  assign side_o = side_q;
  assign v_o    = v_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/core/scsm_div_cell.sv =====
// ----------------------------------------------------------------------------
// scsm_div_cell
// One quotient bit of two restoring dividers: root by max(|a|,|b|) and by 127.
// ----------------------------------------------------------------------------
module scsm_div_cell
  import scsm_pkg::*;
#(
  parameter int unsigned RW = 24,
  parameter int unsigned QW = 17,
  parameter int unsigned I  = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  side_t         side_i,
  input  logic [RW-1:0] rem_m_i,
  input  logic [QW-1:0] q_m_i,
  input  logic [RW-1:0] rem_c_i,
  input  logic [QW-1:0] q_c_i,
  output side_t         side_o,
  output logic [RW-1:0] rem_m_o,
  output logic [QW-1:0] q_m_o,
  output logic [RW-1:0] rem_c_o,
  output logic [QW-1:0] q_c_o
);

  logic [RW:0]   dm, dc;
  logic [RW-1:0] rem_m_d, rem_c_d;
  logic [QW-1:0] q_m_d, q_c_d;
  side_t         side_q;
  logic [RW-1:0] rem_m_q, rem_c_q;
  logic [QW-1:0] q_m_q, q_c_q;

  assign dm = (RW+1)'(side_i.m) << I;
  assign dc = (RW+1)'(CENTER) << I;

  always_comb begin
    rem_m_d = rem_m_i;
    q_m_d   = q_m_i;
    rem_c_d = rem_c_i;
    q_c_d   = q_c_i;
    if ({1'b0, rem_m_i} >= dm) begin
      rem_m_d  = RW'({1'b0, rem_m_i} - dm);
      q_m_d[I] = 1'b1;
    end
    if ({1'b0, rem_c_i} >= dc) begin
      rem_c_d  = RW'({1'b0, rem_c_i} - dc);
      q_c_d[I] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_m_q <= rem_m_d;
      q_m_q   <= q_m_d;
      rem_c_q <= rem_c_d;
      q_c_q   <= q_c_d;
    end
  end

  assign side_o  = side_q;
  assign rem_m_o = rem_m_q;
  assign q_m_o   = q_m_q;
  assign rem_c_o = rem_c_q;
  assign q_c_o   = q_c_q;

endmodule

// ===== rtl/core/scsm_pow_cell.sv =====
// ----------------------------------------------------------------------------
// scsm_pow_cell
// One factor of the radius power: multiplies by the radius when J is below the roundness.
// ----------------------------------------------------------------------------
module scsm_pow_cell
  import scsm_pkg::*;
#(
  parameter int unsigned FB = 16,
  parameter int unsigned FW = 24,
  parameter int unsigned QW = 17,
  parameter int unsigned J  = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [CFG_WIDTH-1:0] roundness_i,
  input  side_t                side_i,
  input  logic [FW-1:0]        f_i,
  input  logic [QW-1:0]        s_i,
  input  logic [QW-1:0]        l_i,
  output side_t                side_o,
  output logic [FW-1:0]        f_o,
  output logic [QW-1:0]        s_o,
  output logic [QW-1:0]        l_o
);

  logic [FW+QW-1:0] prod;
  logic [FW-1:0]    f_d;
  side_t            side_q;
  logic [FW-1:0]    f_q;
  logic [QW-1:0]    s_q, l_q;

  assign prod = (FW+QW)'(f_i) * (FW+QW)'(l_i);
  assign f_d  = (CFG_WIDTH'(J) < roundness_i) ? prod[FB+FW-1:FB] : f_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q <= f_d;
      s_q <= s_i;
      l_q <= l_i;
    end
  end

  assign side_o = side_q;
  assign f_o    = f_q;
  assign s_o    = s_q;
  assign l_o    = l_q;

endmodule

// ===== rtl/core/stick_circle_to_square_map_core.sv =====
// ----------------------------------------------------------------------------
// stick_circle_to_square_map_core
// Maps an 8-bit stick sample from the unit circle onto the unit square.
// ----------------------------------------------------------------------------
// The input channel takes one request per cycle unless the chain is stalled
// (in_valid_i, in_stall_o), carrying stick_x_i and stick_y_i. Every request
// yields exactly one result on the output channel (out_valid_o, out_stall_i)
// with square_x_o and square_y_o, in the same order.
// The chain has one entry stage, FRAC_BITS+8 square root cells, FRAC_BITS+1
// divider cells, 15 power cells, then gain, sum and saturation stages.
// Throughput is one sample per cycle while the output is not stalled; each
// cell resolves one root or quotient bit, or one radius factor, per cycle.
// When the output holds a result and the receiver stalls, the whole chain
// freezes and in_stall_o is raised until the result is taken.
// The roundness register is written through cfg_valid_i/cfg_data_i, always
// ready, and should be changed only while the block is empty.
// Reset clears all valid bits and sets the roundness to zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stick_circle_to_square_map_core
  import scsm_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_WIDTH-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           stick_x_i,
  input  logic [7:0]           stick_y_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           square_x_o,
  output logic [7:0]           square_y_o
);

  localparam int unsigned W   = 16 + 2 * FRAC_BITS;
  localparam int unsigned NSQ = W / 2;
  localparam int unsigned RW  = FRAC_BITS + 8;
  localparam int unsigned QW  = FRAC_BITS + 1;
  localparam int unsigned FW  = FRAC_BITS + 8;
  localparam int unsigned KW  = FRAC_BITS + 8;
  localparam int unsigned TW  = FRAC_BITS + 18;

  logic                 en;
  logic [CFG_WIDTH-1:0] roundness_q;

  assign cfg_ready_o = 1'b1;
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roundness_q <= '0;
    end else if (cfg_valid_i) begin
      roundness_q <= cfg_data_i;
    end
  end

  // Entry stage: center the sample and square the radius.
  side_t             ent_d;
  logic [7:0]        ua, ub;
  logic [15:0]       r2;
  side_t             ent_q;
  logic [W-1:0]      ent_v_q;

  always_comb begin
    ent_d.valid = in_valid_i;
    ent_d.a     = $signed({1'b0, stick_x_i}) - 9'sd127;
    ent_d.b     = 9'sd127 - $signed({1'b0, stick_y_i});
    ua          = 8'(ent_d.a[8] ? -ent_d.a : ent_d.a);
    ub          = 8'(ent_d.b[8] ? -ent_d.b : ent_d.b);
    ent_d.m     = (ua > ub) ? ua : ub;
    r2          = 16'(ua) * 16'(ua) + 16'(ub) * 16'(ub);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else if (en) begin
      ent_q <= ent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ent_v_q <= {r2, {(2 * FRAC_BITS){1'b0}}};
    end
  end

  // Square root chain.
  side_t        sq_s [0:NSQ];
  logic [W-1:0] sq_v [0:NSQ];
  logic [W-1:0] sq_r [0:NSQ];

  assign sq_s[0] = ent_q;
  assign sq_v[0] = ent_v_q;
  assign sq_r[0] = '0;

  for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
    scsm_sqrt_cell #(.W(W), .SH(2 * (NSQ - 1 - g))) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .side_i (sq_s[g]),
      .v_i    (sq_v[g]),
      .res_i  (sq_r[g]),
      .side_o (sq_s[g+1]),
      .v_o    (sq_v[g+1]),
      .res_o  (sq_r[g+1])
    );
  end

  // Divider chain: scale and normalized radius.
  side_t         dv_s  [0:QW];
  logic [RW-1:0] dv_rm [0:QW];
  logic [QW-1:0] dv_qm [0:QW];
  logic [RW-1:0] dv_rc [0:QW];
  logic [QW-1:0] dv_qc [0:QW];

  assign dv_s[0]  = sq_s[NSQ];
  assign dv_rm[0] = sq_r[NSQ][RW-1:0];
  assign dv_rc[0] = sq_r[NSQ][RW-1:0];
  assign dv_qm[0] = '0;
  assign dv_qc[0] = '0;

  for (genvar g = 0; g < QW; g++) begin : g_div
    scsm_div_cell #(.RW(RW), .QW(QW), .I(QW - 1 - g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .side_i  (dv_s[g]),
      .rem_m_i (dv_rm[g]),
      .q_m_i   (dv_qm[g]),
      .rem_c_i (dv_rc[g]),
      .q_c_i   (dv_qc[g]),
      .side_o  (dv_s[g+1]),
      .rem_m_o (dv_rm[g+1]),
      .q_m_o   (dv_qm[g+1]),
      .rem_c_o (dv_rc[g+1]),
      .q_c_o   (dv_qc[g+1])
    );
  end

  // Power chain: f = L^n with truncation after every factor.
  side_t         pw_s [0:MAX_POW];
  logic [FW-1:0] pw_f [0:MAX_POW];
  logic [QW-1:0] pw_sc [0:MAX_POW];
  logic [QW-1:0] pw_l [0:MAX_POW];

  assign pw_s[0]  = dv_s[QW];
  assign pw_f[0]  = FW'(1) << FRAC_BITS;
  assign pw_sc[0] = dv_qm[QW];
  assign pw_l[0]  = dv_qc[QW];

  for (genvar g = 0; g < MAX_POW; g++) begin : g_pow
    scsm_pow_cell #(.FB(FRAC_BITS), .FW(FW), .QW(QW), .J(g)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (en),
      .roundness_i (roundness_q),
      .side_i      (pw_s[g]),
      .f_i         (pw_f[g]),
      .s_i         (pw_sc[g]),
      .l_i         (pw_l[g]),
      .side_o      (pw_s[g+1]),
      .f_o         (pw_f[g+1]),
      .s_o         (pw_sc[g+1]),
      .l_o         (pw_l[g+1])
    );
  end

  // Gain stage. A centered sample keeps unit gain.
  logic [QW-1:0]    sm1;
  logic [FW+QW-1:0] gprod;
  logic [KW-1:0]    k_d, k_q;
  side_t            k_side_q;

  assign sm1   = pw_sc[MAX_POW] - (QW'(1) << FRAC_BITS);
  assign gprod = (FW+QW)'(pw_f[MAX_POW]) * (FW+QW)'(sm1);
  assign k_d   = (pw_s[MAX_POW].m == 8'd0) ? (KW'(1) << FRAC_BITS)
               : KW'(gprod >> FRAC_BITS) + (KW'(1) << FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_side_q <= '0;
    end else if (en) begin
      k_side_q <= pw_s[MAX_POW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      k_q <= k_d;
    end
  end

  // Sum stage.
  logic signed [TW-1:0] base;
  logic signed [KW:0]   k_s;
  logic signed [TW-1:0] tx_d, ty_d, tx_q, ty_q;
  logic                 t_valid_q;

  assign base = TW'(CENTER) << FRAC_BITS;
  assign k_s  = $signed({1'b0, k_q});
  assign tx_d = base + k_side_q.a * k_s;
  assign ty_d = base - k_side_q.b * k_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_valid_q <= 1'b0;
    end else if (en) begin
      t_valid_q <= k_side_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tx_q <= tx_d;
      ty_q <= ty_d;
    end
  end

  // Saturation and output register.
  function automatic logic [7:0] sat8(input logic signed [TW-1:0] t);
    logic signed [TW-1:0] hi;
    hi = t >>> FRAC_BITS;
    if (t < 0) begin
      sat8 = 8'd0;
    end else if (hi > 255) begin
      sat8 = 8'd255;
    end else begin
      sat8 = hi[7:0];
    end
  endfunction

  logic       out_valid_q;
  logic [7:0] sx_q, sy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= t_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q <= sat8(tx_q);
      sy_q <= sat8(ty_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign square_x_o  = sx_q;
  assign square_y_o  = sy_q;

  // The projection never shrinks a point.
  `ASSERT_AR(a_scale_ge_one, clk_i, rst_ni,
    (dv_s[QW].valid && dv_s[QW].m != 8'd0) |-> (dv_qm[QW] >= (QW'(1) << FRAC_BITS)))
  `ASSERT_AR(a_gain_ge_one, clk_i, rst_ni,
    k_side_q.valid |-> (k_q >= (KW'(1) << FRAC_BITS)))
  `ASSERT_AR(a_center_sum, clk_i, rst_ni,
    (en && k_side_q.valid && k_side_q.m == 8'd0) |=> (tx_q == base && ty_q == base))

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stick circle-to-square mapper testbench
// Sends directed and random stick samples under several roundness settings,
// with random gaps and output stalls, and checks every result, in order from a
// queue, against a fixed-point model of the mapping or a known directed row.
// ----------------------------------------------------------------------------
module tb
  import scsm_pkg::*;
();

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned LATENCY   = 2 * FRAC_BITS + 28;
  localparam longint      LIMIT     = 400000;
  localparam int unsigned N_RANDOM  = 1440;

  typedef struct packed {
    logic [7:0] sx;
    logic [7:0] sy;
  } pos_t;

  typedef struct {
    logic [7:0] sx;
    logic [7:0] sy;
    logic       known;
    logic [7:0] ex;
    logic [7:0] ey;
  } row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_WIDTH-1:0] cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [7:0]           stick_x_i;
  logic [7:0]           stick_y_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [7:0]           square_x_o;
  logic [7:0]           square_y_o;

  logic [CFG_WIDTH-1:0] roundness;
  pos_t                 pending_q[$];
  int unsigned          n_errors;
  longint               cycle_cnt;
  bit                   calm;

  stick_circle_to_square_map_core #(.FRAC_BITS(FRAC_BITS)) dut (.*);

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   -= res + bitv;
        res  = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [7:0] saturate(longint t);
    longint unsigned v;
    if (t < 0) return 8'd0;
    v = longint'(t) >>> FRAC_BITS;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic pos_t map_to_square(logic [7:0] sx, logic [7:0] sy,
                                         logic [CFG_WIDTH-1:0] n);
    longint          a, b, tx, ty;
    longint unsigned ua, ub, m, root, s, len, f, k;
    pos_t            p;
    a  = longint'(sx) - CENTER;
    b  = CENTER - longint'(sy);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    m  = (ua > ub) ? ua : ub;
    k  = 64'd1 << FRAC_BITS;
    if (m != 0) begin
      root = int_sqrt((ua * ua + ub * ub) << (2 * FRAC_BITS));
      s    = root / m;
      len  = root / CENTER;
      f    = 64'd1 << FRAC_BITS;
      for (int i = 0; i < n; i++) f = (f * len) >> FRAC_BITS;
      k = (64'd1 << FRAC_BITS) + ((f * (s - (64'd1 << FRAC_BITS))) >> FRAC_BITS);
    end
    tx = (longint'(CENTER) << FRAC_BITS) + a * longint'(k);
    ty = (longint'(CENTER) << FRAC_BITS) - b * longint'(k);
    p.sx = saturate(tx);
    p.sy = saturate(ty);
    return p;
  endfunction

  task automatic report(string msg);
    $display("mismatch: %s at cycle %0d", msg, cycle_cnt);
    n_errors++;
  endtask

  // Output side: random stalls, check each taken result.
  always @(posedge clk_i) begin
    pos_t want;
    if (rst_ni) begin
      cycle_cnt <= cycle_cnt + 1;
      if (out_valid_o && !out_stall_i) begin
        if (pending_q.size() == 0) begin
          report($sformatf("unexpected result %0d,%0d", square_x_o, square_y_o));
        end else begin
          want = pending_q.pop_front();
          if (square_x_o !== want.sx) begin
            report($sformatf("square_x got %0d expected %0d", square_x_o, want.sx));
          end
          if (square_y_o !== want.sy) begin
            report($sformatf("square_y got %0d expected %0d", square_y_o, want.sy));
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 37);
  end

  always @(posedge clk_i) begin
    if (cycle_cnt > LIMIT) begin
      $display("timeout at cycle %0d", cycle_cnt);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 5) @(negedge clk_i);
  endtask

  task automatic write_roundness(logic [CFG_WIDTH-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    roundness = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Drives one request; valid stays high until taken.
  task automatic send(logic [7:0] sx, logic [7:0] sy);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    stick_x_i  <= sx;
    stick_y_i  <= sy;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_q = {pending_q, map_to_square(sx, sy, roundness)};
    @(negedge clk_i);
  endtask

  task automatic run_random(int unsigned count);
    logic [7:0] sx, sy;
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: begin
          sx = 8'($urandom_range(255));
          sy = $urandom_range(1) ? 8'd0 : 8'd255;
        end
        1: begin
          sx = $urandom_range(1) ? 8'd0 : 8'd255;
          sy = 8'($urandom_range(255));
        end
        2: begin
          sx = 8'(124 + $urandom_range(6));
          sy = 8'(124 + $urandom_range(6));
        end
        default: begin
          sx = 8'($urandom_range(255));
          sy = 8'($urandom_range(255));
        end
      endcase
      send(sx, sy);
    end
    in_valid_i <= 1'b0;
  endtask

  row_t directed[$];
  logic [CFG_WIDTH-1:0] settings[6] = '{4'd0, 4'd15, 4'd1, 4'd7, 4'd3, 4'd0};

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    stick_x_i   = 8'd0;
    stick_y_i   = 8'd0;
    roundness   = '0;
    n_errors    = 0;
    cycle_cnt   = 0;
    calm        = 1'b0;
    // Center and the four axis ends have gain one and are read off directly.
    directed = '{
      '{8'd127, 8'd127, 1'b1, 8'd127, 8'd127},
      '{8'd254, 8'd127, 1'b1, 8'd254, 8'd127},
      '{8'd0,   8'd127, 1'b1, 8'd0,   8'd127},
      '{8'd127, 8'd0,   1'b1, 8'd127, 8'd0},
      '{8'd127, 8'd254, 1'b1, 8'd127, 8'd254},
      '{8'd255, 8'd127, 1'b0, 8'd0,   8'd0},
      '{8'd127, 8'd255, 1'b0, 8'd0,   8'd0},
      '{8'd255, 8'd255, 1'b0, 8'd0,   8'd0},
      '{8'd0,   8'd0,   1'b0, 8'd0,   8'd0},
      '{8'd255, 8'd0,   1'b0, 8'd0,   8'd0},
      '{8'd0,   8'd255, 1'b0, 8'd0,   8'd0},
      '{8'd217, 8'd37,  1'b0, 8'd0,   8'd0},
      '{8'd37,  8'd217, 1'b0, 8'd0,   8'd0},
      '{8'd128, 8'd126, 1'b0, 8'd0,   8'd0},
      '{8'd170, 8'd85,  1'b0, 8'd0,   8'd0},
      '{8'd1,   8'd128, 1'b0, 8'd0,   8'd0},
      '{8'd85,  8'd170, 1'b0, 8'd0,   8'd0},
      '{8'd200, 8'd20,  1'b0, 8'd0,   8'd0}
    };
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (settings[s]) begin
      write_roundness(settings[s]);
      foreach (directed[i]) begin
        send(directed[i].sx, directed[i].sy);
        if (directed[i].known && roundness == 0) begin
          pending_q[$].sx = directed[i].ex;
          pending_q[$].sy = directed[i].ey;
        end
      end
      in_valid_i <= 1'b0;
      wait_drained();
    end

    // Random roundness per phase, 15 in the last; one phase without any idling.
    for (int p = 0; p < 6; p++) begin
      write_roundness(p == 5 ? 4'd15 : CFG_WIDTH'($urandom_range(15)));
      calm = (p == 2);
      run_random(N_RANDOM / 6);
      calm = 1'b0;
      wait_drained();
    end

    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
